// ----- rtl/mssl_pkg.sv -----
// Shared types and constants for the multi-servo slew limiter.
// No dependencies.
`default_nettype none

package mssl_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MOTOR_LOW    = 2'd0,
    CFG_MOTOR_HIGH   = 2'd1,
    CFG_HOME_POS     = 2'd2,
    CFG_DEFAULT_STEP = 2'd3
  } cfg_idx_t;

  // Input item opcodes
  typedef enum logic {
    OP_SET_TARGET = 1'b0,
    OP_TICK       = 1'b1
  } op_t;

  localparam int unsigned DATA_W = 16;

  // Register reset values
  localparam logic [DATA_W-1:0] MOTOR_LOW_RST    = 16'd1000;
  localparam logic [DATA_W-1:0] MOTOR_HIGH_RST   = 16'd2000;
  localparam logic [DATA_W-1:0] HOME_POS_RST     = 16'd1500;
  localparam logic [DATA_W-1:0] DEFAULT_STEP_RST = 16'd10;

  // Angle range and the constant divide that maps it onto the compare span
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam int unsigned PROD_W  = 24;  // 16-bit span times 8-bit angle
  localparam int unsigned QUO_W   = 16;

  // x/180 == (x>>2)/45; ceil(2^28/45) is exact for 22-bit numerators
  localparam int unsigned RCP_W  = 23;
  localparam int unsigned RCP_SH = 28;
  localparam logic [RCP_W-1:0] RCP_45 = 23'd5965233;

  // Servos with their own step offset
  localparam int unsigned SERVO_SLOW   = 0;
  localparam int unsigned SERVO_FAST   = 3;
  localparam int unsigned SERVO_FASTER = 11;
  localparam logic [DATA_W-1:0] STEP_SLOW_SUB   = 16'd2;
  localparam logic [DATA_W-1:0] STEP_FAST_ADD   = 16'd2;
  localparam logic [DATA_W-1:0] STEP_FASTER_ADD = 16'd5;

endpackage

`default_nettype wire

// ----- rtl/multi_servo_slew_limiter_core.sv -----
// Multi-servo slew limiter: target/current compare memories, angle mapping, tick walk.
// Depends on mssl_pkg.
`default_nettype none

// Set-target item: busy through the product, reciprocal multiply and write-back states; no results.
// Tick item: busy through the walk state and a drain state; results
//   one per cycle, NUM_SERVOS of them on consecutive cycles, the first reaching the ports through
//   the memory read and output registers, paced by the single read port of the position memories. No stall.
// Reset (rst_n low, synchronous) restores the registers and marks every memory entry
//   invalid; an invalid entry reads as the home position reset value.
module multi_servo_slew_limiter_core
  import mssl_pkg::*;
#(
  parameter int unsigned NUM_SERVOS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_op,
  input  wire logic [3:0]        in_servo_index,
  input  wire logic [7:0]        in_angle,
  // results
  output      logic              out_valid,
  output      logic [3:0]        out_servo_number,
  output      logic [DATA_W-1:0] out_compare_value,
  output      logic              out_last,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(NUM_SERVOS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WRT,
    S_TICK,
    S_DRAIN
  } state_t;

  // Configuration registers
  logic [DATA_W-1:0] motor_low_r;
  logic [DATA_W-1:0] motor_high_r;
  logic [DATA_W-1:0] default_step_r;

  // Control and datapath registers
  state_t            state_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  set_idx_r;
  logic              in_range_r;
  logic [7:0]        ang_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;
  logic [QUO_W-1:0]  quo_r;
  logic              proc_vld_r;
  logic [IDX_W-1:0]  proc_idx_r;

  // Memories and their valid bits
  logic [DATA_W-1:0]     cur_mem [NUM_SERVOS];
  logic [DATA_W-1:0]     tgt_mem [NUM_SERVOS];
  logic [NUM_SERVOS-1:0] cur_vld_r;
  logic [NUM_SERVOS-1:0] tgt_vld_r;
  logic [DATA_W-1:0]     cur_rd_r;
  logic [DATA_W-1:0]     tgt_rd_r;
  logic                  cur_rv_r;
  logic                  tgt_rv_r;

  // Output registers
  logic              out_valid_r;
  logic [3:0]        out_servo_number_r;
  logic [DATA_W-1:0] out_compare_value_r;
  logic              out_last_r;

  logic              accept;
  logic              in_range;
  logic [7:0]        ang_sat;
  logic [DATA_W-1:0] span_mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-2+RCP_W-1:0] rcp_prod;
  logic [QUO_W-1:0]  quo_calc;
  logic [DATA_W-1:0] quo_signed;
  logic [DATA_W-1:0] tgt_new;
  logic              tgt_we;
  logic [DATA_W-1:0] cur_val;
  logic [DATA_W-1:0] tgt_val;
  logic [DATA_W-1:0] step;
  logic [17:0]       up_sum;
  logic [17:0]       dn_sum;
  logic [17:0]       tgt_ext;
  logic [DATA_W-1:0] cur_nxt;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(in_servo_index) < 32'(NUM_SERVOS));
  assign ang_sat  = (in_angle > ANGLE_MAX) ? ANGLE_MAX : in_angle;

  // Angle mapping: |span| * angle, then divide by 180 through a reciprocal multiply
  assign span_mag   = neg_r ? (motor_low_r - motor_high_r) : (motor_high_r - motor_low_r);
  assign prod       = {8'd0, span_mag} * {16'd0, ang_r};
  assign rcp_prod   = {{RCP_W{1'b0}}, prod_r[PROD_W-1:2]} * {{(PROD_W-2){1'b0}}, RCP_45};
  assign quo_calc   = rcp_prod[RCP_SH +: QUO_W];
  assign quo_signed = neg_r ? (16'd0 - quo_r) : quo_r;
  assign tgt_new    = motor_low_r + quo_signed;
  assign tgt_we     = (state_r == S_WRT) && in_range_r;

  // Slew step for the entry read last cycle
  assign cur_val = cur_rv_r ? cur_rd_r : HOME_POS_RST;
  assign tgt_val = tgt_rv_r ? tgt_rd_r : HOME_POS_RST;

  always_comb begin
    step = default_step_r;
    if (proc_idx_r == IDX_W'(SERVO_SLOW)) begin
      step = default_step_r - STEP_SLOW_SUB;
    end else if (proc_idx_r == IDX_W'(SERVO_FAST)) begin
      step = default_step_r + STEP_FAST_ADD;
    end else if (proc_idx_r == IDX_W'(SERVO_FASTER)) begin
      step = default_step_r + STEP_FASTER_ADD;
    end
  end

  assign up_sum  = {2'b00, cur_val} + {2'b00, step};
  assign dn_sum  = {2'b00, cur_val} - {2'b00, step};
  assign tgt_ext = {2'b00, tgt_val};

  always_comb begin
    if ($signed(up_sum) < $signed(tgt_ext)) begin
      cur_nxt = up_sum[DATA_W-1:0];
    end else if ($signed(dn_sum) > $signed(tgt_ext)) begin
      cur_nxt = dn_sum[DATA_W-1:0];
    end else begin
      cur_nxt = tgt_val;
    end
  end

  // Configuration writes; the home position is a fixed constant, so writes to its index are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_low_r    <= MOTOR_LOW_RST;
      motor_high_r   <= MOTOR_HIGH_RST;
      default_step_r <= DEFAULT_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MOTOR_LOW:    motor_low_r    <= cfg_wdata;
        CFG_MOTOR_HIGH:   motor_high_r   <= cfg_wdata;
        CFG_DEFAULT_STEP: default_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Memories: one read address (walk counter), read data registered
  always_ff @(posedge clk) begin
    if (proc_vld_r) begin
      cur_mem[proc_idx_r] <= cur_nxt;
    end
    if (tgt_we) begin
      tgt_mem[set_idx_r] <= tgt_new;
    end
    cur_rd_r <= cur_mem[cnt_r];
    tgt_rd_r <= tgt_mem[cnt_r];
    cur_rv_r <= cur_vld_r[cnt_r];
    tgt_rv_r <= tgt_vld_r[cnt_r];
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= '0;
      tgt_vld_r <= '0;
    end else begin
      if (proc_vld_r) begin
        cur_vld_r[proc_idx_r] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_r[set_idx_r] <= 1'b1;
      end
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      proc_vld_r  <= (state_r == S_TICK);
      proc_idx_r  <= cnt_r;
      out_valid_r <= proc_vld_r;
      if (proc_vld_r) begin
        out_servo_number_r  <= proc_idx_r[3:0];
        out_compare_value_r <= cur_nxt;
        out_last_r          <= (proc_idx_r == IDX_W'(NUM_SERVOS - 1));
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            set_idx_r  <= IDX_W'(in_servo_index);
            in_range_r <= in_range;
            ang_r      <= ang_sat;
            neg_r      <= (motor_high_r < motor_low_r);
            state_r    <= (in_op == OP_TICK) ? S_TICK : S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod;
          state_r <= S_DIV;
        end
        S_DIV: begin
          quo_r   <= quo_calc;
          state_r <= S_WRT;
        end
        S_WRT: begin
          state_r <= S_IDLE;
        end
        S_TICK: begin
          if (cnt_r == IDX_W'(NUM_SERVOS - 1)) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          cnt_r   <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_number  = out_servo_number_r;
  assign out_compare_value = out_compare_value_r;
  assign out_last          = out_last_r;

  // Target writes never overlap a tick walk
  a_no_tgt_wr_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    tgt_we |-> !proc_vld_r)
    else $error("target write during tick walk");

  // A tick transfer starts the walk at servo 0
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_TICK) |=> (state_r == S_TICK && cnt_r == '0))
    else $error("tick did not start walk");

  // The last flag marks the final servo of the walk
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_servo_number_r == 4'(NUM_SERVOS - 1)))
    else $error("last flag on wrong servo");

  // Results only follow a processed memory read
  a_out_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(proc_vld_r))
    else $error("result without processed entry");

  // Mapped offset never exceeds the compare span
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRT) |-> (quo_r <= span_mag))
    else $error("angle offset out of range");

endmodule

`default_nettype wire
